// ===== sv/timeline_to_media_frame_map_unit_assert.svh =====
// Assertion macros for the timeline to media frame map unit
`ifndef TIMELINE_TO_MEDIA_FRAME_MAP_UNIT_ASSERT_SVH
`define TIMELINE_TO_MEDIA_FRAME_MAP_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TMFM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TMFM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tmfm_pkg.sv =====
// Shared types, constants and helper functions for the frame map unit
package tmfm_pkg;

  localparam int FRAME_W    = 32;
  localparam int RATIO_FRAC = 16;
  localparam int PROD_W     = 2 * FRAME_W;
  localparam int CFG_ADDR_W = 3;
  localparam int MODE_W     = 2;
  localparam int OUT_USER_W = 3;

  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [PROD_W-1:0]  prod_t;

  localparam frame_t RATE_ONE = frame_t'(1) << RATIO_FRAC;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CLIP_START    = 3'd0,
    CFG_CLIP_DURATION = 3'd1,
    CFG_MEDIA_START   = 3'd2,
    CFG_MEDIA_LENGTH  = 3'd3,
    CFG_PLAY_MODE     = 3'd4,
    CFG_RATE_RATIO    = 3'd5
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_FREEZE   = 2'd0,
    MODE_LOOP     = 2'd1,
    MODE_PINGPONG = 2'd2
  } play_mode_t;

  // one restoring-division stage plus the flags riding along with it
  typedef struct packed {
    logic   v;
    logic   act;
    frame_t len;
    frame_t rem;
    frame_t num;
    logic   qnz;
    logic   qlsb;
  } div_stage_t;

  typedef struct packed {
    logic   v;
    logic   act;
    logic   empty;
    logic   past;
    frame_t off;
  } fin_t;

  // floor(p >> RATIO_FRAC), saturated to the frame range
  function automatic frame_t sat_scale(prod_t p);
    frame_t r;
    if (|p[PROD_W-1:FRAME_W+RATIO_FRAC]) begin
      r = '1;
    end else begin
      r = p[FRAME_W+RATIO_FRAC-1:RATIO_FRAC];
    end
    return r;
  endfunction

  // one quotient bit: shift in the next numerator bit, subtract if it fits
  function automatic div_stage_t div_step(div_stage_t s);
    div_stage_t       r;
    logic [FRAME_W:0] trial;
    logic [FRAME_W:0] dvs;
    logic             ge;
    r     = s;
    trial = {s.rem, s.num[FRAME_W-1]};
    dvs   = {1'b0, s.len};
    ge    = (trial >= dvs);
    r.rem  = ge ? frame_t'(trial - dvs) : trial[FRAME_W-1:0];
    r.num  = {s.num[FRAME_W-2:0], 1'b0};
    r.qnz  = s.qnz | ge;
    r.qlsb = ge;
    return r;
  endfunction

endpackage

// ===== sv/timeline_to_media_frame_map_unit.sv =====
// Top level: maps a timeline frame onto a media frame of one configured clip
//
//   port group | dir | tdata            | tuser
//   in_        | in  | timeline_frame   | -
//   out_       | out | media_frame      | active, past_end, empty_source
//   cfg_       | in  | write: cfg_we, cfg_addr, cfg_wdata
//
// One transfer in and one out per cycle while the skid register is empty; the
// result passes through span check, 32x32 multiply, scale/saturate, a 32-stage
// restoring divider (one quotient bit per stage), fold select, output register.
// A stalled output parks one result in a skid register; the pipeline freezes
// only while that register is full. rst_n is synchronous and clears all valid
// bits and loads the register defaults (rate_ratio = 1.0).

`include "timeline_to_media_frame_map_unit_assert.svh"

module timeline_to_media_frame_map_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [tmfm_pkg::FRAME_W-1:0]           in_tdata,   // [31:0] timeline_frame
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [tmfm_pkg::FRAME_W-1:0]           out_tdata,  // [31:0] media_frame
  output logic [tmfm_pkg::OUT_USER_W-1:0]        out_tuser,  // [0] active, [1] past_end,
                                                             // [2] empty_source
  input  logic                                   cfg_we,
  input  logic [tmfm_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [tmfm_pkg::FRAME_W-1:0]           cfg_wdata
);

  // configuration
  tmfm_pkg::frame_t             clip_start_r;
  tmfm_pkg::frame_t             clip_duration_r;
  tmfm_pkg::frame_t             media_start_r;
  tmfm_pkg::frame_t             media_length_r;
  logic [tmfm_pkg::MODE_W-1:0]  play_mode_r;
  tmfm_pkg::frame_t             rate_ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_start_r    <= '0;
      clip_duration_r <= '0;
      media_start_r   <= '0;
      media_length_r  <= '0;
      play_mode_r     <= tmfm_pkg::MODE_FREEZE;
      rate_ratio_r    <= tmfm_pkg::RATE_ONE;
    end else if (cfg_we) begin
      case (cfg_addr)
        tmfm_pkg::CFG_CLIP_START:    clip_start_r    <= cfg_wdata;
        tmfm_pkg::CFG_CLIP_DURATION: clip_duration_r <= cfg_wdata;
        tmfm_pkg::CFG_MEDIA_START:   media_start_r   <= cfg_wdata;
        tmfm_pkg::CFG_MEDIA_LENGTH:  media_length_r  <= cfg_wdata;
        tmfm_pkg::CFG_PLAY_MODE:     play_mode_r     <= cfg_wdata[tmfm_pkg::MODE_W-1:0];
        tmfm_pkg::CFG_RATE_RATIO:    rate_ratio_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline advance: frozen only while the skid register holds a result
  logic skid_valid_r;
  logic en;

  assign en        = !skid_valid_r;
  assign in_tready = en;

  // stage 1: span check and local frame
  logic             s1_v_r;
  logic             s1_act_r;
  tmfm_pkg::frame_t s1_local_r;
  tmfm_pkg::frame_t span_end;
  logic             in_span;

  assign span_end = clip_start_r + clip_duration_r;   // wraps
  assign in_span  = (in_tdata >= clip_start_r) && (in_tdata < span_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_act_r   <= in_span;
      s1_local_r <= in_tdata - clip_start_r;
    end
  end

  // stage 2: products
  logic            s2_v_r;
  logic            s2_act_r;
  tmfm_pkg::prod_t s2_psrc_r;
  tmfm_pkg::prod_t s2_plen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_act_r  <= s1_act_r;
      s2_psrc_r <= tmfm_pkg::PROD_W'(s1_local_r) * tmfm_pkg::PROD_W'(rate_ratio_r);
      s2_plen_r <= tmfm_pkg::PROD_W'(clip_duration_r) * tmfm_pkg::PROD_W'(rate_ratio_r);
    end
  end

  // stage 3: scale, saturate, pick source length; then the divider chain
  tmfm_pkg::frame_t     src;
  tmfm_pkg::frame_t     len;
  tmfm_pkg::div_stage_t dv0;
  tmfm_pkg::div_stage_t dv_r [tmfm_pkg::FRAME_W+1];

  assign src = tmfm_pkg::sat_scale(s2_psrc_r);
  assign len = (media_length_r != '0) ? media_length_r : tmfm_pkg::sat_scale(s2_plen_r);

  always_comb begin
    dv0      = '0;
    dv0.v    = s2_v_r;
    dv0.act  = s2_act_r;
    dv0.len  = len;
    dv0.num  = src;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= tmfm_pkg::FRAME_W; i++) begin
        dv_r[i].v <= 1'b0;
      end
    end else if (en) begin
      dv_r[0] <= dv0;
      for (int i = 1; i <= tmfm_pkg::FRAME_W; i++) begin
        dv_r[i] <= tmfm_pkg::div_step(dv_r[i-1]);
      end
    end
  end

  // fold stage: remainder and quotient parity select the media offset
  tmfm_pkg::div_stage_t dq;
  tmfm_pkg::fin_t       fin_nxt;
  tmfm_pkg::fin_t       fin_r;

  assign dq = dv_r[tmfm_pkg::FRAME_W];

  always_comb begin
    fin_nxt       = '0;
    fin_nxt.v     = dq.v;
    fin_nxt.act   = dq.act;
    fin_nxt.empty = dq.act && (dq.len == '0);
    fin_nxt.past  = dq.act && (dq.len != '0) && dq.qnz;
    if (fin_nxt.empty) begin
      fin_nxt.off = '0;
    end else if (!fin_nxt.past) begin
      fin_nxt.off = dq.rem;
    end else begin
      case (play_mode_r)
        tmfm_pkg::MODE_LOOP:     fin_nxt.off = dq.rem;
        // odd cycle runs backward: len - 1 - pos
        tmfm_pkg::MODE_PINGPONG: fin_nxt.off = dq.qlsb ? dq.len + ~dq.rem : dq.rem;
        default:                 fin_nxt.off = dq.len - tmfm_pkg::frame_t'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r.v <= 1'b0;
    end else if (en) begin
      fin_r <= fin_nxt;
    end
  end

  // result and output / skid registers
  tmfm_pkg::frame_t                res_data;
  logic [tmfm_pkg::OUT_USER_W-1:0] res_user;
  logic                            out_valid_r;
  tmfm_pkg::frame_t                out_data_r;
  logic [tmfm_pkg::OUT_USER_W-1:0] out_user_r;
  tmfm_pkg::frame_t                skid_data_r;
  logic [tmfm_pkg::OUT_USER_W-1:0] skid_user_r;
  logic                            out_free;

  assign res_data = fin_r.act ? media_start_r + fin_r.off : '0;
  assign res_user = {fin_r.empty, fin_r.past, fin_r.act};
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_tready) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (out_free) begin
      out_valid_r <= fin_r.v;
    end else if (fin_r.v) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_tready) begin
        out_data_r <= skid_data_r;
        out_user_r <= skid_user_r;
      end
    end else if (out_free) begin
      out_data_r <= res_data;
      out_user_r <= res_user;
    end else begin
      skid_data_r <= res_data;
      skid_user_r <= res_user;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // checks
  `TMFM_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r,
                   "skid register full while output register empty")
  `TMFM_ASSERT_NOW(a_inactive_zero, out_valid_r && !out_tuser[0],
                   out_tdata == '0 && !out_tuser[1] && !out_tuser[2],
                   "inactive result carries nonzero fields")
  `TMFM_ASSERT_NOW(a_empty_not_past, out_valid_r && out_tuser[2], !out_tuser[1],
                   "empty source result flagged past end")
  `TMFM_ASSERT_NXT(a_skid_drains, skid_valid_r && out_tready, !skid_valid_r && out_valid_r,
                   "skid result not moved to output on transfer")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the timeline to media frame map unit
module tb_top;

  localparam int HALF_PERIOD  = 6;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 48;
  localparam int RAND_PHASES  = 26;
  localparam int PHASE_FRAMES = 48;
  // spare play mode code, decoded as freeze
  localparam logic [tmfm_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic             active;
    tmfm_pkg::frame_t media;
    logic             past;
    logic             empty;
  } frame_map_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  tmfm_pkg::frame_t                in_tdata   = '0;   // [31:0] timeline_frame
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  tmfm_pkg::frame_t                out_tdata;         // [31:0] media_frame
  logic [tmfm_pkg::OUT_USER_W-1:0] out_tuser;  // [0] active, [1] past_end, [2] empty_source
  logic                            cfg_we     = 1'b0;
  tmfm_pkg::cfg_reg_t              cfg_addr   = tmfm_pkg::CFG_CLIP_START;
  tmfm_pkg::frame_t                cfg_wdata  = '0;

  // shadow copy of the clip registers
  tmfm_pkg::frame_t            clip_start_r  = '0;
  tmfm_pkg::frame_t            clip_dur_r    = '0;
  tmfm_pkg::frame_t            media_start_r = '0;
  tmfm_pkg::frame_t            media_len_r   = '0;
  logic [tmfm_pkg::MODE_W-1:0] mode_r        = tmfm_pkg::MODE_FREEZE;
  tmfm_pkg::frame_t            rate_r        = tmfm_pkg::RATE_ONE;

  tmfm_pkg::frame_t timeline_q[$];
  frame_map_t       media_exp_q[$];
  int               mismatches = 0;
  int               out_count  = 0;
  int               cycles     = 0;
  int               in_gap     = 0;
  int               out_gap    = 0;
  logic             in_acc     = 1'b0;
  bit               calm       = 1'b0;

  timeline_to_media_frame_map_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // frame times ratio, floored, clamped to the frame range
  function automatic tmfm_pkg::frame_t scale_rate(tmfm_pkg::frame_t f,
                                                  tmfm_pkg::frame_t ratio);
    tmfm_pkg::prod_t prod;
    prod = (tmfm_pkg::prod_t'(f) * tmfm_pkg::prod_t'(ratio)) >> tmfm_pkg::RATIO_FRAC;
    return ((prod >> tmfm_pkg::FRAME_W) != 0) ? '1 : prod[tmfm_pkg::FRAME_W-1:0];
  endfunction

  function automatic frame_map_t map_frame(tmfm_pkg::frame_t t);
    frame_map_t       r;
    tmfm_pkg::frame_t span_end;
    tmfm_pkg::frame_t src;
    tmfm_pkg::frame_t len;
    tmfm_pkg::frame_t pos;
    tmfm_pkg::frame_t cyc;
    r = '0;
    span_end = clip_start_r + clip_dur_r;
    if (t >= clip_start_r && t < span_end) begin
      r.active = 1'b1;
      src = scale_rate(t - clip_start_r, rate_r);
      len = (media_len_r != 0) ? media_len_r : scale_rate(clip_dur_r, rate_r);
      if (len == 0) begin
        r.empty = 1'b1;
        r.media = media_start_r;
      end else if (src < len) begin
        r.media = media_start_r + src;
      end else begin
        pos    = src % len;
        cyc    = src / len;
        r.past = 1'b1;
        case (mode_r)
          tmfm_pkg::MODE_LOOP: begin
            r.media = media_start_r + pos;
          end
          tmfm_pkg::MODE_PINGPONG: begin
            r.media = cyc[0] ? media_start_r + (len - 1 - pos) : media_start_r + pos;
          end
          default: begin
            r.media = media_start_r + len - 1;
          end
        endcase
      end
    end
    return r;
  endfunction

  // mostly back to back, sometimes a short gap, rarely a long pause
  function automatic int pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic tmfm_pkg::frame_t pick_frame();
    int unsigned      sel;
    tmfm_pkg::frame_t off;
    sel = $urandom_range(0, 99);
    off = (clip_dur_r != 0) ? tmfm_pkg::frame_t'($urandom) % clip_dur_r : '0;
    if (sel < 25) return clip_start_r + (off & 32'h3F);
    if (sel < 70) return clip_start_r + off;
    if (sel < 75) return clip_start_r + clip_dur_r - $urandom_range(0, 1);
    if (sel < 80) return clip_start_r - $urandom_range(0, 1);
    return $urandom;
  endfunction

  task automatic report_mismatch(string field, tmfm_pkg::frame_t got,
                                 tmfm_pkg::frame_t want);
    $display("mismatch in %s on output transfer %0d: got %h, want %h",
             field, out_count, got, want);
    mismatches++;
  endtask

  // returns at a falling edge once no transfer is pending or outstanding
  task automatic wait_idle();
    @(negedge clk);
    while (timeline_q.size() != 0 || in_tvalid || media_exp_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(tmfm_pkg::cfg_reg_t idx, tmfm_pkg::frame_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      tmfm_pkg::CFG_CLIP_START:    clip_start_r  = val;
      tmfm_pkg::CFG_CLIP_DURATION: clip_dur_r    = val;
      tmfm_pkg::CFG_MEDIA_START:   media_start_r = val;
      tmfm_pkg::CFG_MEDIA_LENGTH:  media_len_r   = val;
      tmfm_pkg::CFG_PLAY_MODE:     mode_r        = val[tmfm_pkg::MODE_W-1:0];
      tmfm_pkg::CFG_RATE_RATIO:    rate_r        = val;
      default: ;
    endcase
  endtask

  // ends on a rising edge so that new frames are queued clear of the driver
  task automatic program_clip(tmfm_pkg::frame_t cs, tmfm_pkg::frame_t dur,
                              tmfm_pkg::frame_t ms, tmfm_pkg::frame_t ml,
                              tmfm_pkg::frame_t mode_word, tmfm_pkg::frame_t ratio);
    wait_idle();
    write_reg(tmfm_pkg::CFG_CLIP_START, cs);
    write_reg(tmfm_pkg::CFG_CLIP_DURATION, dur);
    write_reg(tmfm_pkg::CFG_MEDIA_START, ms);
    write_reg(tmfm_pkg::CFG_MEDIA_LENGTH, ml);
    write_reg(tmfm_pkg::CFG_PLAY_MODE, mode_word);
    write_reg(tmfm_pkg::CFG_RATE_RATIO, ratio);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_clip();
    int unsigned      sel;
    tmfm_pkg::frame_t cs;
    tmfm_pkg::frame_t dur;
    tmfm_pkg::frame_t ms;
    tmfm_pkg::frame_t ml;
    tmfm_pkg::frame_t ratio;
    sel = $urandom_range(0, 99);
    if (sel < 60)      cs = $urandom_range(0, 4096);
    else if (sel < 85) cs = $urandom;
    else               cs = 32'hFFFF_FFFF - $urandom_range(0, 300);
    sel = $urandom_range(0, 99);
    if (sel < 60)      dur = $urandom_range(1, 300);
    else if (sel < 65) dur = '0;
    else if (sel < 80) dur = $urandom_range(1, 5000);
    else if (sel < 95) dur = $urandom;
    else               dur = '1;
    sel = $urandom_range(0, 99);
    if (sel < 50)      ms = $urandom_range(0, 100000);
    else if (sel < 90) ms = $urandom;
    else               ms = 32'hFFFF_FFFF - $urandom_range(0, 64);
    sel = $urandom_range(0, 99);
    if (sel < 25)      ml = '0;
    else if (sel < 75) ml = $urandom_range(1, 40);
    else if (sel < 90) ml = $urandom_range(41, 100000);
    else               ml = $urandom;
    case ($urandom_range(0, 9))
      0:       ratio = tmfm_pkg::RATE_ONE;
      1:       ratio = tmfm_pkg::RATE_ONE >> 1;
      2:       ratio = tmfm_pkg::RATE_ONE << 1;
      3:       ratio = tmfm_pkg::RATE_ONE * 24 / 30;   // 24 fps clip on a 30 fps timeline
      4:       ratio = $urandom_range(0, 4 * tmfm_pkg::RATE_ONE);
      5:       ratio = $urandom;
      6:       ratio = '1;
      7:       ratio = '0;
      8:       ratio = $urandom_range(tmfm_pkg::RATE_ONE / 8, tmfm_pkg::RATE_ONE);
      default: ratio = tmfm_pkg::RATE_ONE * 30 / 24;
    endcase
    // upper bits of the mode word are don't-care and get random junk
    program_clip(cs, dur, ms, ml, $urandom, ratio);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: zero duration, never active
    timeline_q.push_back('0);
    timeline_q.push_back('1);

    program_clip(100, 50, 1000, 10, tmfm_pkg::frame_t'(tmfm_pkg::MODE_FREEZE),
                 tmfm_pkg::RATE_ONE);
    timeline_q.push_back(99);
    timeline_q.push_back(100);
    timeline_q.push_back(109);
    timeline_q.push_back(110);
    timeline_q.push_back(149);
    timeline_q.push_back(150);

    program_clip(100, 50, 1000, 10, tmfm_pkg::frame_t'(tmfm_pkg::MODE_LOOP),
                 tmfm_pkg::RATE_ONE);
    timeline_q.push_back(125);

    program_clip(100, 50, 1000, 10, tmfm_pkg::frame_t'(tmfm_pkg::MODE_PINGPONG),
                 tmfm_pkg::RATE_ONE);
    timeline_q.push_back(115);
    timeline_q.push_back(125);

    program_clip(100, 50, 1000, 10, tmfm_pkg::frame_t'(MODE_SPARE), tmfm_pkg::RATE_ONE);
    timeline_q.push_back(130);

    // zero ratio with derived length: empty source
    program_clip(100, 50, 1000, 0, tmfm_pkg::frame_t'(tmfm_pkg::MODE_LOOP), '0);
    timeline_q.push_back(100);
    timeline_q.push_back(149);

    // span end wraps past zero
    program_clip(32'hFFFF_FFF0, 32, 500, 8, tmfm_pkg::frame_t'(tmfm_pkg::MODE_LOOP),
                 tmfm_pkg::RATE_ONE);
    timeline_q.push_back(32'hFFFF_FFF5);
    timeline_q.push_back(5);
    timeline_q.push_back('1);

    // saturated product and media frame wrapping at 32 bits
    program_clip('0, '1, 32'hFFFF_FFF0, '0, tmfm_pkg::frame_t'(tmfm_pkg::MODE_LOOP), '1);
    timeline_q.push_back('0);
    timeline_q.push_back(32'hFFFF_FFFE);
    timeline_q.push_back(1);

    for (int p = 0; p < RAND_PHASES; p++) begin
      random_clip();
      calm = ($urandom_range(0, 4) == 0);
      for (int n = 0; n < PHASE_FRAMES; n++)
        timeline_q.push_back(pick_frame());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && media_exp_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // sender
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_acc) begin
        if (in_gap > 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (timeline_q.size() != 0) begin
          in_tdata  <= timeline_q.pop_front();
          in_tvalid <= 1'b1;
          in_gap    <= calm ? 0 : pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_tready <= 1'b0;
      out_gap    <= out_gap - 1;
    end else begin
      out_tready <= 1'b1;
      out_gap    <= calm ? 0 : pick_gap();
    end
  end

  always @(posedge clk) begin
    frame_map_t got;
    frame_map_t want;
    if (!rst_n) begin
      in_acc <= 1'b0;
    end else begin
      in_acc <= in_tvalid && in_tready;
      if (in_tvalid && in_tready)
        media_exp_q.push_back(map_frame(in_tdata));
      if (out_tvalid && out_tready) begin
        got.active = out_tuser[0];
        got.media  = out_tdata;
        got.past   = out_tuser[1];
        got.empty  = out_tuser[2];
        if (media_exp_q.size() == 0) begin
          report_mismatch("unexpected transfer", got.media, '0);
        end else begin
          want = media_exp_q.pop_front();
          if (got.active !== want.active)
            report_mismatch("active", tmfm_pkg::frame_t'(got.active),
                            tmfm_pkg::frame_t'(want.active));
          if (got.media !== want.media)
            report_mismatch("media_frame", got.media, want.media);
          if (got.past !== want.past)
            report_mismatch("past_end", tmfm_pkg::frame_t'(got.past),
                            tmfm_pkg::frame_t'(want.past));
          if (got.empty !== want.empty)
            report_mismatch("empty_source", tmfm_pkg::frame_t'(got.empty),
                            tmfm_pkg::frame_t'(want.empty));
        end
        out_count <= out_count + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
